// ----- sv/channel_id_allocator_demux_macros.svh -----
// Assertion macros shared by the checker of the channel id allocator.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef CHANNEL_ID_ALLOCATOR_DEMUX_MACROS_SVH
`define CHANNEL_ID_ALLOCATOR_DEMUX_MACROS_SVH

// A property checked on every rising edge outside reset.
`define CIDA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled word must keep its valid and its payload.
`define CIDA_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

// ----- sv/cida_pkg.sv -----
// Types and codes shared by the channel id allocator and demultiplexer.
// Depends on nothing; imported by every module of the block.
package cida_pkg;

    localparam int CIDA_MAX_IDS = 16;
    localparam int CIDA_QDEPTH  = 2;
    localparam int CIDA_QPW     = 1;

    localparam logic [2:0] CMD_TRUNK_UP   = 3'd0;
    localparam logic [2:0] CMD_TRUNK_DOWN = 3'd1;
    localparam logic [2:0] CMD_OPEN       = 3'd2;
    localparam logic [2:0] CMD_CLOSE      = 3'd3;
    localparam logic [2:0] CMD_BYTE       = 3'd4;

    typedef enum logic [2:0] {
        EV_GRANT   = 3'd0,
        EV_REFUSE  = 3'd1,
        EV_PAYLOAD = 3'd2,
        EV_CONTROL = 3'd3,
        EV_SHUT    = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        OP_UP    = 3'd0,
        OP_DOWN  = 3'd1,
        OP_OPEN  = 3'd2,
        OP_CLOSE = 3'd3,
        OP_BYTE  = 3'd4
    } t_op_kind;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic [4:0] close_id;
    } t_in_item;

    typedef struct packed {
        t_event     event_res;
        logic [4:0] chan_id;
        logic [7:0] payload;
        logic       frame_last;
    } t_out_item;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data_byte;
        logic [4:0] close_id;
    } t_op;

endpackage

// ----- sv/cida_front.sv -----
// Front end: accepts input words, drops those that can have no effect and
// classifies the rest into operations. Depends on cida_pkg.
module cida_front #(
    parameter int MAX_IDS = cida_pkg::CIDA_MAX_IDS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cida_pkg::t_in_item i_in_data,
    output logic               o_op_valid,
    input  logic               i_op_ready,
    output cida_pkg::t_op      o_op
);
    import cida_pkg::*;

    logic r_valid;
    t_op  r_op;
    t_op  n_op;
    logic n_keep;

    always_comb begin
        n_op.data_byte = i_in_data.data_byte;
        n_op.close_id  = i_in_data.close_id;
        n_op.kind      = OP_UP;
        n_keep         = 1'b1;
        case (i_in_data.cmd)
            CMD_TRUNK_UP:   n_op.kind = OP_UP;
            CMD_TRUNK_DOWN: n_op.kind = OP_DOWN;
            CMD_OPEN:       n_op.kind = OP_OPEN;
            CMD_CLOSE: begin
                // A close of an id outside the pool can never match an open id.
                n_op.kind = OP_CLOSE;
                n_keep    = (i_in_data.close_id != 5'd0) &&
                            (32'(i_in_data.close_id) <= MAX_IDS);
            end
            CMD_BYTE:       n_op.kind = OP_BYTE;
            default:        n_keep = 1'b0;
        endcase
    end

    assign o_in_ready = !r_valid || i_op_ready;
    assign o_op_valid = r_valid;
    assign o_op       = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_op <= n_op;
        end
    end

endmodule

// ----- sv/cida_queue.sv -----
// Short operation queue between the front end and the back end.
// Depends on cida_pkg.
module cida_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  cida_pkg::t_op i_push_op,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output cida_pkg::t_op o_pop_op
);
    import cida_pkg::*;

    localparam int CW = $clog2(CIDA_QDEPTH + 1);

    t_op                 r_mem [CIDA_QDEPTH];
    logic [CIDA_QPW-1:0] r_wr;
    logic [CIDA_QPW-1:0] r_rd;
    logic [CW-1:0]       r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = r_count != CW'(CIDA_QDEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_op     = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [CIDA_QPW-1:0] step(input logic [CIDA_QPW-1:0] p);
        return (p == CIDA_QPW'(CIDA_QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= step(r_wr);
            end
            if (pop) begin
                r_rd <= step(r_rd);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_op;
        end
    end

endmodule

// ----- sv/cida_back.sv -----
// Back end: id pool, returned-id queue, open table, frame parser and the
// output register. Depends on cida_pkg.
module cida_back #(
    parameter int MAX_IDS = cida_pkg::CIDA_MAX_IDS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_op_valid,
    output logic                o_op_ready,
    input  cida_pkg::t_op       i_op,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cida_pkg::t_out_item o_out_data
);
    import cida_pkg::*;

    localparam int IW = $clog2(MAX_IDS + 1);
    localparam int FW = $clog2(MAX_IDS + 2);
    localparam int PW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

    typedef enum logic [3:0] {
        PH_LEN   = 4'b0001,
        PH_ID_LO = 4'b0010,
        PH_ID_HI = 4'b0100,
        PH_BODY  = 4'b1000
    } t_phase;

    logic              r_trunk_up,   n_trunk_up;
    logic [FW-1:0]     r_fresh_next, n_fresh_next;
    logic [PW-1:0]     r_head,       n_head;
    logic [PW-1:0]     r_tail,       n_tail;
    logic [IW-1:0]     r_count,      n_count;
    logic [MAX_IDS:1]  r_open_map,   n_open_map;
    t_phase            r_phase,      n_phase;
    logic [7:0]        r_bytes_left, n_bytes_left;
    logic [15:0]       r_frame_chan, n_frame_chan;
    logic              r_route_ok,   n_route_ok;
    logic              r_out_valid;
    t_out_item         r_out,        n_out;
    logic              n_emit;

    logic [IW-1:0]     r_fifo [MAX_IDS];
    logic [IW-1:0]     r_head_q;
    logic              wr_en;
    logic [IW-1:0]     wr_data;

    logic              fire;
    logic [IW-1:0]     cl_id;
    logic [IW-1:0]     grant_id;
    logic [15:0]       fc;
    logic [7:0]        left_dec;

    function automatic logic [PW-1:0] wrap(input logic [PW-1:0] p);
        return (p == PW'(MAX_IDS - 1)) ? '0 : p + 1'b1;
    endfunction

    assign fire       = i_op_valid && (!r_out_valid || i_out_ready);
    assign o_op_ready = fire;
    assign cl_id      = IW'(i_op.close_id);
    assign fc         = {i_op.data_byte, r_frame_chan[7:0]};
    assign left_dec   = (r_bytes_left != 8'd0) ? r_bytes_left - 8'd1 : 8'd0;

    always_comb begin
        n_trunk_up   = r_trunk_up;
        n_fresh_next = r_fresh_next;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_open_map   = r_open_map;
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_frame_chan = r_frame_chan;
        n_route_ok   = r_route_ok;
        n_emit       = 1'b0;
        n_out        = '{event_res: EV_REFUSE, chan_id: 5'd0, payload: 8'd0,
                         frame_last: 1'b0};
        wr_en        = 1'b0;
        wr_data      = cl_id;
        grant_id     = '0;
        if (fire) begin
            case (i_op.kind)
                OP_UP: begin
                    if (!r_trunk_up) begin
                        n_trunk_up   = 1'b1;
                        n_fresh_next = FW'(1);
                        n_head       = '0;
                        n_tail       = '0;
                        n_count      = '0;
                        n_open_map   = '0;
                        n_phase      = PH_LEN;
                        n_bytes_left = 8'd0;
                        n_frame_chan = 16'd0;
                        n_route_ok   = 1'b0;
                    end
                end
                OP_DOWN: begin
                    n_trunk_up      = 1'b0;
                    n_fresh_next    = FW'(MAX_IDS + 1);
                    n_head          = '0;
                    n_tail          = '0;
                    n_count         = '0;
                    n_open_map      = '0;
                    n_phase         = PH_LEN;
                    n_bytes_left    = 8'd0;
                    n_frame_chan    = 16'd0;
                    n_route_ok      = 1'b0;
                    n_emit          = 1'b1;
                    n_out.event_res = EV_SHUT;
                end
                OP_OPEN: begin
                    n_emit = 1'b1;
                    // Fresh ids are all granted before any returned id.
                    if (r_trunk_up && r_fresh_next <= FW'(MAX_IDS)) begin
                        grant_id     = IW'(r_fresh_next);
                        n_fresh_next = r_fresh_next + 1'b1;
                    end else if (r_trunk_up && r_count != '0) begin
                        grant_id = r_head_q;
                        n_head   = wrap(r_head);
                        n_count  = r_count - 1'b1;
                    end
                    if (grant_id != '0) begin
                        n_open_map[grant_id] = 1'b1;
                        n_out.event_res      = EV_GRANT;
                        n_out.chan_id        = 5'(grant_id);
                    end
                end
                OP_CLOSE: begin
                    if (r_trunk_up && r_open_map[cl_id]) begin
                        n_open_map[cl_id] = 1'b0;
                        if (r_count < IW'(MAX_IDS)) begin
                            wr_en   = 1'b1;
                            n_tail  = wrap(r_tail);
                            n_count = r_count + 1'b1;
                        end
                        if (r_phase == PH_BODY && r_frame_chan == 16'(cl_id)) begin
                            n_route_ok = 1'b0;
                        end
                    end
                end
                OP_BYTE: begin
                    if (r_trunk_up) begin
                        case (r_phase)
                            PH_LEN: begin
                                n_bytes_left = i_op.data_byte;
                                n_phase      = PH_ID_LO;
                            end
                            PH_ID_LO: begin
                                n_frame_chan = {8'd0, i_op.data_byte};
                                n_phase      = PH_ID_HI;
                            end
                            PH_ID_HI: begin
                                n_frame_chan = fc;
                                n_route_ok   = (fc != 16'd0) && (32'(fc) <= MAX_IDS) &&
                                               r_open_map[IW'(fc)];
                                n_phase      = (r_bytes_left == 8'd0) ? PH_LEN : PH_BODY;
                            end
                            PH_BODY: begin
                                n_bytes_left = left_dec;
                                if (left_dec == 8'd0) begin
                                    n_phase = PH_LEN;
                                end
                                n_out.payload    = i_op.data_byte;
                                n_out.frame_last = left_dec == 8'd0;
                                if (r_frame_chan == 16'd0) begin
                                    n_emit          = 1'b1;
                                    n_out.event_res = EV_CONTROL;
                                end else if (r_route_ok) begin
                                    n_emit          = 1'b1;
                                    n_out.event_res = EV_PAYLOAD;
                                    n_out.chan_id   = 5'(r_frame_chan);
                                end
                            end
                            default: n_phase = PH_LEN;
                        endcase
                    end
                end
                default: n_emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trunk_up   <= 1'b0;
            r_fresh_next <= FW'(1);
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_open_map   <= '0;
            r_phase      <= PH_LEN;
            r_bytes_left <= 8'd0;
            r_frame_chan <= 16'd0;
            r_route_ok   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_trunk_up   <= n_trunk_up;
            r_fresh_next <= n_fresh_next;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_open_map   <= n_open_map;
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_frame_chan <= n_frame_chan;
            r_route_ok   <= n_route_ok;
            if (fire) begin
                r_out_valid <= n_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    // The queue head is read ahead into a register, with a bypass for a word written
    // to the very entry that becomes the head.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fifo[r_tail] <= wr_data;
        end
        if (wr_en && r_tail == n_head) begin
            r_head_q <= wr_data;
        end else begin
            r_head_q <= r_fifo[n_head];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- sv/channel_id_allocator_demux.sv -----
// Channel id allocator and trunk demultiplexer, top level.
// Throughput: one word per cycle while the output is not stalled, set by the back end
// updating the pool, open table and frame parser once per cycle; a two-entry queue
// absorbs stalls.
// Reset is synchronous and active low; the returned-id store is not cleared.
module channel_id_allocator_demux #(
    parameter int MAX_IDS = cida_pkg::CIDA_MAX_IDS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cida_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cida_pkg::t_out_item o_out_data
);
    import cida_pkg::*;

    logic f_valid, f_ready;
    t_op  f_op;
    logic q_valid, q_ready;
    t_op  q_op;

    cida_front #(.MAX_IDS(MAX_IDS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_op_valid (f_valid),
        .i_op_ready (f_ready),
        .o_op       (f_op)
    );

    cida_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_op    (f_op),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_op     (q_op)
    );

    cida_back #(.MAX_IDS(MAX_IDS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .o_op_ready  (q_ready),
        .i_op        (q_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- sv/cida_checker.sv -----
// Port checker for the channel id allocator, bound to the top level.
// Depends on cida_pkg and channel_id_allocator_demux_macros.svh.
`include "channel_id_allocator_demux_macros.svh"

module cida_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input cida_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input cida_pkg::t_out_item o_out_data
);
    import cida_pkg::*;

    logic in_seen;
    assign in_seen = i_in_valid && o_in_ready && (i_in_data.cmd != CMD_TRUNK_UP);

    // Nothing can be pending straight after reset.
    `CIDA_ASSERT(a_quiet_after_reset, i_clk, i_rst_n, $rose(i_rst_n) |-> !o_out_valid, "result after reset")

    `CIDA_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_out_valid, i_out_ready, o_out_data, "stalled result changed")

    // Refusals and shutdowns carry no id, byte or frame end.
    `CIDA_ASSERT(a_bare_events, i_clk, i_rst_n, (o_out_valid && (o_out_data.event_res == EV_REFUSE || o_out_data.event_res == EV_SHUT)) |-> (o_out_data.chan_id == 5'd0 && o_out_data.payload == 8'd0 && !o_out_data.frame_last), "refuse or shut with data")

    // A granted id is never zero and carries no byte.
    `CIDA_ASSERT(a_grant_id, i_clk, i_rst_n, (o_out_valid && o_out_data.event_res == EV_GRANT) |-> (o_out_data.chan_id != 5'd0 && o_out_data.payload == 8'd0 && !o_out_data.frame_last), "bad grant")

    // Control bytes belong to channel zero; payload bytes never do.
    `CIDA_ASSERT(a_control_chan, i_clk, i_rst_n, (o_out_valid && (o_out_data.event_res == EV_CONTROL || (o_out_data.event_res == EV_PAYLOAD && !in_seen))) |-> ((o_out_data.event_res == EV_CONTROL) == (o_out_data.chan_id == 5'd0)), "channel of byte")

endmodule

bind channel_id_allocator_demux cida_checker u_cida_checker (.*);
